[hw/rtl/residual_color_run_decoder_macros.svh]
// Assertion macros for the residual color run decoder.
`ifndef RESIDUAL_COLOR_RUN_DECODER_MACROS_SVH
`define RESIDUAL_COLOR_RUN_DECODER_MACROS_SVH

// check a condition at every clock edge outside reset
`define RCRD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define RCRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rcrd_pkg.sv]
// Shared types and constants for the residual color run decoder.
package rcrd_pkg;

  localparam logic [7:0]  ESC8  = 8'hFF;
  localparam logic [15:0] ESC16 = 16'hFFFF;
  localparam logic [31:0] CONSUMED_MAX = 32'hFFFF_FFFF;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_RUN   = 2'd2;
  localparam logic [1:0] ERR_TOTAL = 2'd3;

  typedef enum logic [9:0] {
    PH_BLUE  = 10'b00_0000_0001,
    PH_GREEN = 10'b00_0000_0010,
    PH_RED   = 10'b00_0000_0100,
    PH_LEN8  = 10'b00_0000_1000,
    PH_L16A  = 10'b00_0001_0000,
    PH_L16B  = 10'b00_0010_0000,
    PH_L32A  = 10'b00_0100_0000,
    PH_L32B  = 10'b00_1000_0000,
    PH_L32C  = 10'b01_0000_0000,
    PH_L32D  = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] run_start;
    logic [31:0] run_length;
    logic        run_valid;
    logic        frame_done;
    logic [1:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic [31:0] byte_count;
    logic [31:0] total_pixels;
  } cfg_t;

endpackage

[hw/rtl/residual_color_run_decoder.sv]
// Top level of the residual color run decoder: input and result registers.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   rcrd_pkg::in_item_t
//   out_     output     out_valid / out_stall rcrd_pkg::out_item_t
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One byte per cycle sustained while the result is not stalled. A byte waits in
// the input register, its result in the result register; the combinational parse
// step between them sets the rate. rst_n clears the frame state and valid bits.
// A stalled result holds the pipe; the input register still fills behind it.
`include "residual_color_run_decoder_macros.svh"

module residual_color_run_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rcrd_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rcrd_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [rcrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcrd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  rcrd_pkg::cfg_t      cfg;
  rcrd_pkg::in_item_t  s1_item_r;
  logic                s1_valid_r, s1_valid_nxt;
  rcrd_pkg::out_item_t out_item_r;
  logic                out_valid_r, out_valid_nxt;
  rcrd_pkg::out_item_t step_result;
  logic                step_has_result;
  logic                advance;
  logic                in_take;

  rcrd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rcrd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (s1_item_r),
    .cfg        (cfg),
    .has_result (step_has_result),
    .result     (step_result)
  );

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance && step_has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance && step_has_result) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `RCRD_ASSERT_IMPL(a_err_needs_done, out_valid_r && out_item_r.error_code != rcrd_pkg::ERR_OK, out_item_r.frame_done, "error code without frame end")
  `RCRD_ASSERT_IMPL(a_result_not_empty, out_valid_r && !out_item_r.run_valid, out_item_r.frame_done, "result carries neither run nor frame end")
  `RCRD_ASSERT_IMPL(a_run_err_no_run, out_valid_r && out_item_r.error_code == rcrd_pkg::ERR_RUN, !out_item_r.run_valid, "overlong run reported as painted")
  `RCRD_ASSERT_ALWAYS(a_no_step_when_blocked, !(advance && out_valid_r && out_stall), "parse step while result is blocked")

endmodule

[hw/rtl/rcrd_cfg_regs.sv]
// Configuration registers and precomputed tile pixel count.
module rcrd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rcrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output rcrd_pkg::cfg_t                      cfg
);

  logic [31:0] count_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [31:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      total_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcrd_pkg::CFG_BYTE_COUNT: begin
          count_r <= cfg_wdata;
        end
        rcrd_pkg::CFG_WIDTH: begin
          width_r <= cfg_wdata[15:0];
          total_r <= {16'b0, cfg_wdata[15:0]} * {16'b0, height_r};
        end
        rcrd_pkg::CFG_HEIGHT: begin
          height_r <= cfg_wdata[15:0];
          total_r  <= {16'b0, width_r} * {16'b0, cfg_wdata[15:0]};
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.byte_count   = count_r;
  assign cfg.total_pixels = total_r;

endmodule

[hw/rtl/rcrd_parser.sv]
// Record parser: frame state and the per-byte step.
module rcrd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  rcrd_pkg::in_item_t   item,
  input  rcrd_pkg::cfg_t       cfg,
  output logic                 has_result,
  output rcrd_pkg::out_item_t  result
);

  rcrd_pkg::phase_t phase_r, phase_nxt, ph_e;
  logic [31:0] consumed_r, consumed_nxt, cons_e;
  logic [31:0] pixels_r, pixels_nxt, pix_e;
  logic [23:0] color_r, color_nxt, col_e;
  logic [31:0] acc_r, acc_nxt, acc_e;
  logic        finished_r, finished_nxt, fin_e;

  logic        rec_done;
  logic        run_ok;
  logic        done;
  logic [1:0]  err;
  logic [32:0] sum;
  logic [31:0] byte_ext;

  always_comb begin
    ph_e   = item.frame_start ? rcrd_pkg::PH_BLUE : phase_r;
    cons_e = item.frame_start ? '0 : consumed_r;
    pix_e  = item.frame_start ? '0 : pixels_r;
    col_e  = item.frame_start ? '0 : color_r;
    acc_e  = item.frame_start ? '0 : acc_r;
    fin_e  = item.frame_start ? 1'b0 : finished_r;

    byte_ext     = {24'b0, item.data_byte};
    phase_nxt    = ph_e;
    consumed_nxt = cons_e;
    pixels_nxt   = pix_e;
    color_nxt    = col_e;
    acc_nxt      = acc_e;
    finished_nxt = fin_e;
    rec_done     = 1'b0;
    run_ok       = 1'b0;
    done         = 1'b0;
    err          = rcrd_pkg::ERR_OK;
    sum          = '0;

    if (fin_e) begin
      done = 1'b0;
    end else if (ph_e == rcrd_pkg::PH_BLUE && cons_e >= cfg.byte_count) begin
      done = 1'b1;
      err  = (pix_e == cfg.total_pixels) ? rcrd_pkg::ERR_OK : rcrd_pkg::ERR_TOTAL;
    end else begin
      if (cons_e != rcrd_pkg::CONSUMED_MAX) begin
        consumed_nxt = cons_e + 32'd1;
      end
      unique case (ph_e)
        rcrd_pkg::PH_BLUE: begin
          color_nxt = {16'b0, item.data_byte};
          phase_nxt = rcrd_pkg::PH_GREEN;
        end
        rcrd_pkg::PH_GREEN: begin
          color_nxt = {col_e[23:16], item.data_byte, col_e[7:0]};
          phase_nxt = rcrd_pkg::PH_RED;
        end
        rcrd_pkg::PH_RED: begin
          color_nxt = {item.data_byte, col_e[15:0]};
          phase_nxt = rcrd_pkg::PH_LEN8;
        end
        rcrd_pkg::PH_LEN8: begin
          if (item.data_byte == rcrd_pkg::ESC8) begin
            phase_nxt = rcrd_pkg::PH_L16A;
          end else begin
            acc_nxt  = byte_ext;
            rec_done = 1'b1;
          end
        end
        rcrd_pkg::PH_L16A: begin
          acc_nxt   = byte_ext;
          phase_nxt = rcrd_pkg::PH_L16B;
        end
        rcrd_pkg::PH_L16B: begin
          acc_nxt = acc_e | (byte_ext << 8);
          if (acc_nxt[15:0] == rcrd_pkg::ESC16 && acc_nxt[31:16] == 16'b0) begin
            phase_nxt = rcrd_pkg::PH_L32A;
          end else begin
            rec_done = 1'b1;
          end
        end
        rcrd_pkg::PH_L32A: begin
          acc_nxt   = byte_ext;
          phase_nxt = rcrd_pkg::PH_L32B;
        end
        rcrd_pkg::PH_L32B: begin
          acc_nxt   = acc_e | (byte_ext << 8);
          phase_nxt = rcrd_pkg::PH_L32C;
        end
        rcrd_pkg::PH_L32C: begin
          acc_nxt   = acc_e | (byte_ext << 16);
          phase_nxt = rcrd_pkg::PH_L32D;
        end
        default: begin
          acc_nxt  = acc_e | (byte_ext << 24);
          rec_done = 1'b1;
        end
      endcase

      if (rec_done) begin
        phase_nxt = rcrd_pkg::PH_BLUE;
        sum = {1'b0, pix_e} + {1'b0, acc_nxt};
        if (sum > {1'b0, cfg.total_pixels}) begin
          done = 1'b1;
          err  = rcrd_pkg::ERR_RUN;
        end else begin
          run_ok     = 1'b1;
          pixels_nxt = sum[31:0];
          if (consumed_nxt >= cfg.byte_count) begin
            done = 1'b1;
            err  = (sum[31:0] == cfg.total_pixels) ? rcrd_pkg::ERR_OK
                                                    : rcrd_pkg::ERR_TOTAL;
          end
        end
      end

      if (!done && item.stream_end) begin
        done = 1'b1;
        err  = rcrd_pkg::ERR_SHORT;
      end
    end

    if (done) begin
      finished_nxt = 1'b1;
    end

    has_result        = run_ok || done;
    result.red        = run_ok ? col_e[23:16] : 8'b0;
    result.green      = run_ok ? col_e[15:8]  : 8'b0;
    result.blue       = run_ok ? col_e[7:0]   : 8'b0;
    result.run_start  = run_ok ? pix_e : 32'b0;
    result.run_length = run_ok ? acc_nxt : 32'b0;
    result.run_valid  = run_ok;
    result.frame_done = done;
    result.error_code = err;

    if (rec_done) begin
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rcrd_pkg::PH_BLUE;
      consumed_r <= '0;
      pixels_r   <= '0;
      color_r    <= '0;
      acc_r      <= '0;
      finished_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      consumed_r <= consumed_nxt;
      pixels_r   <= pixels_nxt;
      color_r    <= color_nxt;
      acc_r      <= acc_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule
